/* rtl/core/assert_macros.svh */
// Assertion macros shared by the sequencer core modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

/* rtl/core/pls_pkg.sv */
// Shared types and constants for the pedestrian light sequencer core.
package pls_pkg;

   localparam int TIME_W    = 16;
   localparam int TOUCH_W   = 8;
   localparam int CODE_W    = 3;
   localparam int CSR_IDX_W = 3;

   // Register indexes on the csr port.
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_GREEN_HOLD     = 3'd0,
      REG_YELLOW         = 3'd1,
      REG_RED            = 3'd2,
      REG_RED_YELLOW     = 3'd3,
      REG_RED_BEEP_HALF  = 3'd4,
      REG_GREEN_BEEP_ON  = 3'd5,
      REG_GREEN_BEEP_OFF = 3'd6
   } reg_index_type;

   localparam logic [TIME_W-1:0] RST_GREEN_HOLD     = 16'd5000;
   localparam logic [TIME_W-1:0] RST_YELLOW         = 16'd2000;
   localparam logic [TIME_W-1:0] RST_RED            = 16'd10000;
   localparam logic [TIME_W-1:0] RST_RED_YELLOW     = 16'd2000;
   localparam logic [TIME_W-1:0] RST_RED_BEEP_HALF  = 16'd250;
   localparam logic [TIME_W-1:0] RST_GREEN_BEEP_ON  = 16'd500;
   localparam logic [TIME_W-1:0] RST_GREEN_BEEP_OFF = 16'd1500;

   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   // Lamp sequencer state.
   typedef enum logic [4:0] {
      PH_RED        = 5'b00001,
      PH_RED_YELLOW = 5'b00010,
      PH_WAIT       = 5'b00100,
      PH_HOLD       = 5'b01000,
      PH_YELLOW     = 5'b10000
   } phase_type;

   // Phase codes as seen on the result channel.
   localparam logic [CODE_W-1:0] CODE_RED        = 3'd0;
   localparam logic [CODE_W-1:0] CODE_RED_YELLOW = 3'd1;
   localparam logic [CODE_W-1:0] CODE_WAIT       = 3'd2;
   localparam logic [CODE_W-1:0] CODE_HOLD       = 3'd3;
   localparam logic [CODE_W-1:0] CODE_YELLOW     = 3'd4;

   typedef struct packed {
      logic [TIME_W-1:0] green_hold;
      logic [TIME_W-1:0] yellow;
      logic [TIME_W-1:0] red;
      logic [TIME_W-1:0] red_yellow;
      logic [TIME_W-1:0] red_beep_half;
      logic [TIME_W-1:0] green_beep_on;
      logic [TIME_W-1:0] green_beep_off;
   } cfg_type;

   typedef struct packed {
      logic              red_lamp;
      logic              yellow_lamp;
      logic              green_lamp;
      logic              beeper_on;
      logic [CODE_W-1:0] phase_code;
   } lamps_type;

endpackage

/* rtl/core/pedestrian_light_sequencer_core.sv */
// Top level of the pedestrian light sequencer core.
//
//  channel  direction  handshake          payload
//  req      in         req_valid/stall    req_touch_status[7:0]
//  rsp      out        rsp_valid/stall    lamps, beeper, rsp_phase_code[2:0]
//  csr      in         csr_valid/ready    csr_index[2:0], csr_wdata[15:0]
//
// One tick per cycle while rsp_stall is low: a transaction is first held in
// the input register, then the sequencer update runs and its result lands in
// the result register. rsp_valid rises once the tick has passed the input
// register and then been written into the result register.
// Reset returns the lamps to red, clears both timers and loads the default
// timing registers. A stalled result holds the result register; the input
// register keeps accepting until it too is full, then req_stall rises.
`include "assert_macros.svh"

module pedestrian_light_sequencer_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [pls_pkg::TOUCH_W-1:0]    req_touch_status,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_red_lamp,
   output logic                           rsp_yellow_lamp,
   output logic                           rsp_green_lamp,
   output logic                           rsp_beeper_on,
   output logic [pls_pkg::CODE_W-1:0]     rsp_phase_code,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [pls_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pls_pkg::TIME_W-1:0]     csr_wdata
);
   import pls_pkg::*;

   logic               s1_valid_ff;
   logic               s1_valid_in;
   logic [TOUCH_W-1:0] s1_touch_ff;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   lamps_type          rsp_ff;
   lamps_type          lamps;
   cfg_type            cfg;
   logic               advance;
   logic               accept;

   // The csr bank takes a write in any cycle.
   assign csr_ready = 1'b1;

   pls_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Advance the tick held in the input register whenever the result
   // register is empty or being emptied this cycle.
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   pls_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .touch_status (s1_touch_ff),
      .cfg          (cfg),
      .lamps        (lamps)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      // Hold a stalled result, drop a delivered one.
      rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers, no reset needed.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_touch_ff <= req_touch_status;
      end
      if (advance) begin
         rsp_ff <= lamps;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_red_lamp    = rsp_ff.red_lamp;
   assign rsp_yellow_lamp = rsp_ff.yellow_lamp;
   assign rsp_green_lamp  = rsp_ff.green_lamp;
   assign rsp_beeper_on   = rsp_ff.beeper_on;
   assign rsp_phase_code  = rsp_ff.phase_code;

   // A tick that advances always shows up as a result next cycle.
   `ASSERT_NEXT(a_advance_yields_rsp, clock, reset, advance, rsp_valid)
   // Outside yellow exactly one of red and green is lit.
   `ASSERT_IMPLIES(a_red_green_excl, clock, reset,
      rsp_valid && rsp_phase_code != CODE_YELLOW, rsp_red_lamp != rsp_green_lamp)
   // Phase code and lamps agree on the yellow phase.
   `ASSERT_IMPLIES(a_yellow_lamps, clock, reset,
      rsp_valid && rsp_phase_code == CODE_YELLOW,
      rsp_yellow_lamp && !rsp_red_lamp && !rsp_green_lamp)

endmodule

/* rtl/core/pls_regs.sv */
// Timing register bank written through the csr port.
module pls_regs (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write,
   input  logic [pls_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pls_pkg::TIME_W-1:0]     csr_wdata,
   output pls_pkg::cfg_type               cfg
);
   import pls_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (reg_index_type'(csr_index))
            REG_GREEN_HOLD:     cfg_in.green_hold     = csr_wdata;
            REG_YELLOW:         cfg_in.yellow         = csr_wdata;
            REG_RED:            cfg_in.red            = csr_wdata;
            REG_RED_YELLOW:     cfg_in.red_yellow     = csr_wdata;
            REG_RED_BEEP_HALF:  cfg_in.red_beep_half  = csr_wdata;
            REG_GREEN_BEEP_ON:  cfg_in.green_beep_on  = csr_wdata;
            REG_GREEN_BEEP_OFF: cfg_in.green_beep_off = csr_wdata;
            default:            cfg_in = cfg_ff;  // drop writes past the list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.green_hold     <= RST_GREEN_HOLD;
         cfg_ff.yellow         <= RST_YELLOW;
         cfg_ff.red            <= RST_RED;
         cfg_ff.red_yellow     <= RST_RED_YELLOW;
         cfg_ff.red_beep_half  <= RST_RED_BEEP_HALF;
         cfg_ff.green_beep_on  <= RST_GREEN_BEEP_ON;
         cfg_ff.green_beep_off <= RST_GREEN_BEEP_OFF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/core/pls_seq.sv */
// Phase sequencer and beeper timer, one update per tick.
`include "assert_macros.svh"

module pls_seq (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  logic [pls_pkg::TOUCH_W-1:0]  touch_status,
   input  pls_pkg::cfg_type             cfg,
   output pls_pkg::lamps_type           lamps
);
   import pls_pkg::*;

   phase_type         phase_ff;
   phase_type         phase_in;
   logic [TIME_W-1:0] phase_elapsed_ff;
   logic [TIME_W-1:0] phase_elapsed_in;
   logic [TIME_W-1:0] beep_elapsed_ff;
   logic [TIME_W-1:0] beep_elapsed_in;
   logic              beep_state_ff;
   logic              beep_state_in;

   logic              red_now;
   logic [TIME_W-1:0] interval;
   logic [TIME_W-1:0] beep_inc;
   logic [TIME_W-1:0] phase_inc;
   logic [TIME_W-1:0] dur;
   phase_type         nxt;
   logic              timed;

   // Beeper: interval follows the lamps at the start of the tick.
   always_comb begin
      case (phase_ff)
         PH_WAIT, PH_HOLD, PH_YELLOW: red_now = 1'b0;
         default:                     red_now = 1'b1;
      endcase
      if (red_now) begin
         interval = cfg.red_beep_half;
      end else begin
         interval = beep_state_ff ? cfg.green_beep_on : cfg.green_beep_off;
      end
      beep_inc = (beep_elapsed_ff == TIME_MAX) ? beep_elapsed_ff
                                               : beep_elapsed_ff + 16'd1;
      if (beep_inc >= interval) begin
         beep_state_in   = ~beep_state_ff;
         beep_elapsed_in = '0;
      end else begin
         beep_state_in   = beep_state_ff;
         beep_elapsed_in = beep_inc;
      end
   end

   // Phase: waiting green reacts to touch, every other phase runs its timer.
   always_comb begin
      timed = 1'b1;
      case (phase_ff)
         PH_WAIT: begin
            timed = 1'b0;
            dur   = cfg.red;
            nxt   = PH_HOLD;
         end
         PH_HOLD: begin
            dur = cfg.green_hold;
            nxt = PH_YELLOW;
         end
         PH_YELLOW: begin
            dur = cfg.yellow;
            nxt = PH_RED;
         end
         PH_RED_YELLOW: begin
            dur = cfg.red_yellow;
            nxt = PH_WAIT;
         end
         default: begin
            dur = cfg.red;
            nxt = PH_RED_YELLOW;
         end
      endcase
      phase_inc = (phase_elapsed_ff == TIME_MAX) ? phase_elapsed_ff
                                                 : phase_elapsed_ff + 16'd1;
      phase_in         = phase_ff;
      phase_elapsed_in = phase_elapsed_ff;
      if (!timed) begin
         if (touch_status != '0) begin
            phase_in         = nxt;
            phase_elapsed_in = '0;
         end
      end else if (phase_inc >= dur) begin
         phase_in         = nxt;
         phase_elapsed_in = '0;
      end else begin
         phase_elapsed_in = phase_inc;
      end
   end

   // Result shows the state after the tick.
   always_comb begin
      lamps           = '0;
      lamps.beeper_on = beep_state_in;
      case (phase_in)
         PH_RED_YELLOW: begin
            lamps.red_lamp    = 1'b1;
            lamps.yellow_lamp = 1'b1;
            lamps.phase_code  = CODE_RED_YELLOW;
         end
         PH_WAIT: begin
            lamps.green_lamp = 1'b1;
            lamps.phase_code = CODE_WAIT;
         end
         PH_HOLD: begin
            lamps.green_lamp = 1'b1;
            lamps.phase_code = CODE_HOLD;
         end
         PH_YELLOW: begin
            lamps.yellow_lamp = 1'b1;
            lamps.phase_code  = CODE_YELLOW;
         end
         default: begin
            lamps.red_lamp   = 1'b1;
            lamps.phase_code = CODE_RED;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_RED;
         phase_elapsed_ff <= '0;
         beep_elapsed_ff  <= '0;
         beep_state_ff    <= 1'b0;
      end else if (step) begin
         phase_ff         <= phase_in;
         phase_elapsed_ff <= phase_elapsed_in;
         beep_elapsed_ff  <= beep_elapsed_in;
         beep_state_ff    <= beep_state_in;
      end
   end

   // Waiting green without a touch stays in waiting green.
   `ASSERT_NEXT(a_wait_holds, clock, reset,
      step && phase_ff == PH_WAIT && touch_status == '0, phase_ff == PH_WAIT)

endmodule
